[rtl/gla_pkg.sv]
// Shared types and constants of the gas level alarm controller.
// Used by gas_level_alarm_controller and its testbench; depends on nothing.
package gla_pkg;

   localparam int LEVEL_W   = 12;
   localparam int SAMPLE_BITS = 12;
   localparam int HZ_W      = 6;
   localparam int TIME_W    = 32;
   localparam int HALF_W    = 16;
   localparam int PROD_W    = LEVEL_W + HZ_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int BLINK_NUM = 1000;

   localparam logic [1:0] WARN_NONE   = 2'd0;
   localparam logic [1:0] WARN_LOW    = 2'd1;
   localparam logic [1:0] WARN_HIGH   = 2'd2;
   localparam logic [1:0] WARN_SEVERE = 2'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_NONE_TH,
      REG_LOW_TH,
      REG_HIGH_TH,
      REG_MIN_HZ,
      REG_MAX_HZ
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WAIT_Q,
      ST_WAIT_H,
      ST_FLIP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [1:0]        pad;
      logic              reset_pressed;
      logic              toggle_pressed;
      logic [TIME_W-1:0] now_ms;
      logic [LEVEL_W-1:0] gas_sample;
   } req_type;

   typedef struct packed {
      logic [3:0]         pad;
      logic               relay_on;
      logic               buzzer_on;
      logic               blue_on;
      logic               green_on;
      logic               red_on;
      logic [1:0]         warn_level;
      logic               active_flag;
      logic [LEVEL_W-1:0] shown_level;
   } rsp_type;

endpackage

[rtl/gla_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Stand-alone; depends on nothing.
module gla_div #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
`endif

endmodule

[rtl/gas_level_alarm_controller.sv]
// Top level of the gas level alarm controller: registers, sequencer, LED decode.
// Depends on gla_pkg and gla_div.
//
//  channel  ports          payload
//  input    req_t*         gas_sample, now_ms, toggle_pressed, reset_pressed
//  result   rsp_t*         shown_level, active_flag, warn_level, red/green/blue,
//                          buzzer_on, relay_on
//  config   csr_*          one register write per cycle at csr_addr
//
// Warn levels 0 to 2: after the input transfer the sequencer goes through ST_FLIP to ST_OUT.
// A reset press gives no result; the input is ready again the next cycle.
// Warn level 3: ST_MUL, then two 18-step passes through the shared divider
// (rate, then half period), then ST_FLIP and ST_OUT; one pass when the rate is fixed.
// Synchronous reset sets mode, blink state and config registers to defaults; no clearing pass.
// The input is not ready from transfer until the result transfers; rsp_tready low
// holds off the next input.
module gas_level_alarm_controller
   import gla_pkg::*;
#(
   parameter int SLOW_HALF_PERIOD_MS = 500
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // gas_sample[11:0], now_ms[43:12], toggle_pressed[44], reset_pressed[45]
   input  logic [47:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // shown_level[11:0], active_flag[12], warn_level[14:13], red_on[15],
   // green_on[16], blue_on[17], buzzer_on[18], relay_on[19]
   output logic [23:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEN_W = SAMPLE_BITS;
   localparam logic [16:0] FULL_SCALE = 17'((1 << SAMPLE_BITS) - 1);
   localparam logic [LEVEL_W-1:0] SAMPLE_MASK = LEVEL_W'(FULL_SCALE);

   state_type state_ff, state_in;

   logic [LEVEL_W-1:0] none_th_ff, low_th_ff, high_th_ff;
   logic [HZ_W-1:0]    min_hz_ff, max_hz_ff;
   logic               live_ff, live_in;
   logic [LEVEL_W-1:0] frozen_ff, frozen_in;
   logic               phase_ff, phase_in;
   logic [TIME_W-1:0]  last_flip_ff, last_flip_in;
   logic [TIME_W-1:0]  now_ff;
   logic [1:0]         warn_ff, warn_in;
   logic [HALF_W-1:0]  half_ff;
   rsp_type            rsp_ff, rsp_in;

   req_type            req;
   logic               req_fire;
   logic [LEVEL_W-1:0] sample_m;

   logic               div_start, div_done;
   logic [PROD_W-1:0]  div_num, div_quo;
   logic [DEN_W-1:0]   div_den;

   logic               degen;
   logic [LEVEL_W-1:0] over;
   logic [HZ_W-1:0]    hz_diff, f_deg, f_lin, f_sev;
   logic [PROD_W:0]    q_sum;
   logic [PROD_W-1:0]  product;
   logic [DEN_W-1:0]   den_lin;
   logic [TIME_W-1:0]  elapsed;
   logic               do_flip;

   assign req        = req_type'(req_tdata);
   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign sample_m   = req.gas_sample & SAMPLE_MASK;
   assign rsp_tvalid = state_ff == ST_OUT;
   assign rsp_tdata  = rsp_ff;

   // level-three rate arithmetic
   always_comb begin
      degen   = ({5'b0, high_th_ff} >= FULL_SCALE) || (max_hz_ff < min_hz_ff);
      over    = (frozen_ff > high_th_ff) ? frozen_ff - high_th_ff : '0;
      hz_diff = max_hz_ff - min_hz_ff;
      product = PROD_W'(over) * PROD_W'(hz_diff);
      den_lin = DEN_W'(FULL_SCALE - {5'b0, high_th_ff});
      f_deg   = (max_hz_ff == '0) ? HZ_W'(1) : max_hz_ff;
      q_sum   = (PROD_W+1)'(min_hz_ff) + (PROD_W+1)'(div_quo);
      f_lin   = (q_sum > (PROD_W+1)'(max_hz_ff)) ? max_hz_ff : HZ_W'(q_sum);
      f_sev   = (f_lin == '0) ? HZ_W'(1) : f_lin;
   end

   // grade the shown level, update mode on transfer
   always_comb begin
      live_in   = live_ff;
      frozen_in = frozen_ff;
      phase_in  = phase_ff;
      if (req.reset_pressed) begin
         live_in   = 1'b1;
         frozen_in = sample_m;
         phase_in  = 1'b0;
      end else begin
         live_in = live_ff ^ req.toggle_pressed;
         if (live_in) begin
            frozen_in = sample_m;
         end
      end
      if (frozen_in < none_th_ff) begin
         warn_in = WARN_NONE;
      end else if (frozen_in < low_th_ff) begin
         warn_in = WARN_LOW;
      end else if (frozen_in < high_th_ff) begin
         warn_in = WARN_HIGH;
      end else begin
         warn_in = WARN_SEVERE;
      end
   end

   // blink flip and result
   always_comb begin
      elapsed      = now_ff - last_flip_ff;
      do_flip      = warn_ff[1] && (elapsed >= TIME_W'(half_ff));
      last_flip_in = do_flip ? now_ff : last_flip_ff;
      rsp_in             = '0;
      rsp_in.shown_level = frozen_ff;
      rsp_in.active_flag = live_ff;
      rsp_in.warn_level  = warn_ff;
      rsp_in.blue_on     = warn_ff == WARN_NONE;
      rsp_in.green_on    = warn_ff == WARN_LOW;
      rsp_in.red_on      = (warn_ff == WARN_LOW) || (warn_ff[1] && (phase_ff ^ do_flip));
      rsp_in.buzzer_on   = (warn_ff == WARN_SEVERE) && !(phase_ff ^ do_flip);
      rsp_in.relay_on    = warn_ff == WARN_SEVERE;
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = product;
      div_den   = den_lin;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !req.reset_pressed) begin
               state_in = (warn_in == WARN_SEVERE) ? ST_MUL : ST_FLIP;
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            if (degen) begin
               div_num  = PROD_W'(BLINK_NUM);
               div_den  = DEN_W'(f_deg);
               state_in = ST_WAIT_H;
            end else begin
               state_in = ST_WAIT_Q;
            end
         end
         ST_WAIT_Q: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = PROD_W'(BLINK_NUM);
               div_den   = DEN_W'(f_sev);
               state_in  = ST_WAIT_H;
            end
         end
         ST_WAIT_H: begin
            if (div_done) begin
               state_in = ST_FLIP;
            end
         end
         ST_FLIP: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         none_th_ff <= LEVEL_W'(200);
         low_th_ff  <= LEVEL_W'(1000);
         high_th_ff <= LEVEL_W'(3000);
         min_hz_ff  <= HZ_W'(2);
         max_hz_ff  <= HZ_W'(10);
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_NONE_TH: none_th_ff <= csr_wdata;
            REG_LOW_TH:  low_th_ff  <= csr_wdata;
            REG_HIGH_TH: high_th_ff <= csr_wdata;
            REG_MIN_HZ:  min_hz_ff  <= csr_wdata[HZ_W-1:0];
            REG_MAX_HZ:  max_hz_ff  <= csr_wdata[HZ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= 1'b1;
         frozen_ff    <= '0;
         phase_ff     <= 1'b0;
         last_flip_ff <= '0;
      end else if (req_fire) begin
         live_ff   <= live_in;
         frozen_ff <= frozen_in;
         phase_ff  <= phase_in;
      end else if (state_ff == ST_FLIP) begin
         phase_ff     <= phase_ff ^ do_flip;
         last_flip_ff <= last_flip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff  <= req.now_ms;
         warn_ff <= warn_in;
         half_ff <= HALF_W'(SLOW_HALF_PERIOD_MS);
      end else if (state_ff == ST_WAIT_H && div_done) begin
         half_ff <= HALF_W'(div_quo[PROD_W-1:1]);
      end
      if (state_ff == ST_FLIP) begin
         rsp_ff <= rsp_in;
      end
   end

   gla_div #(
      .NUM_W(PROD_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quo  (div_quo)
   );

`ifndef SYNTHESIS
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input ready while result pending");
   a_flip_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLIP) |=> rsp_tvalid) else $error("result not presented");
   a_reset_press: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.reset_pressed) |=> !rsp_tvalid && req_tready)
      else $error("reset press produced a result");
   a_led_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot({rsp_ff.blue_on, rsp_ff.green_on,
                              rsp_ff.warn_level == WARN_HIGH, rsp_ff.relay_on}))
      else $error("LED decode not exclusive");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for gas_level_alarm_controller: streams loop passes in,
// predicts LED, buzzer and relay results in a scoreboard class and checks each transfer.
// Depends on gla_pkg and the controller RTL only.
module tb
   import gla_pkg::*;
();

   localparam int unsigned FULL_SCALE = (1 << SAMPLE_BITS) - 1;
   localparam int unsigned SLOW_HALF_MS = 500;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      logic [LEVEL_W-1:0] none_th;
      logic [LEVEL_W-1:0] low_th;
      logic [LEVEL_W-1:0] high_th;
      logic [HZ_W-1:0]    min_hz;
      logic [HZ_W-1:0]    max_hz;
   } alarm_settings_type;

   class alarm_scoreboard;
      alarm_settings_type thr;
      bit                 live_mode;
      logic [LEVEL_W-1:0] frozen_level;
      bit                 blink_phase;
      logic [TIME_W-1:0]  last_flip_ms;
      rsp_type            pending_alarms[$];
      int                 failures;

      function new();
         thr = '{12'd200, 12'd1000, 12'd3000, 6'd2, 6'd10};
         live_mode = 1'b1;
         frozen_level = '0;
         blink_phase = 1'b0;
         last_flip_ms = '0;
         failures = 0;
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(reg_index_type idx);
         case (idx)
            REG_NONE_TH: return thr.none_th;
            REG_LOW_TH:  return thr.low_th;
            REG_HIGH_TH: return thr.high_th;
            REG_MIN_HZ:  return CSR_DATA_W'(thr.min_hz);
            default:     return CSR_DATA_W'(thr.max_hz);
         endcase
      endfunction

      function int unsigned severe_half_ms(int unsigned lvl);
         int unsigned rate;
         int unsigned over;
         if (thr.high_th >= FULL_SCALE || thr.max_hz < thr.min_hz) begin
            rate = 32'(thr.max_hz);
         end else begin
            over = (lvl > thr.high_th) ? lvl - 32'(thr.high_th) : 0;
            rate = 32'(thr.min_hz) + (over * 32'(thr.max_hz - thr.min_hz)) /
                   (FULL_SCALE - 32'(thr.high_th));
            if (rate > thr.max_hz) rate = 32'(thr.max_hz);
         end
         if (rate == 0) rate = 1;
         return (BLINK_NUM / rate) / 2;
      endfunction

      function void advance_blink(logic [TIME_W-1:0] now, int unsigned half);
         logic [TIME_W-1:0] gap;
         gap = now - last_flip_ms;
         if (gap >= half) begin
            blink_phase = !blink_phase;
            last_flip_ms = now;
         end
      endfunction

      function void predict_pass(req_type item);
         rsp_type want;
         want = '0;
         if (item.reset_pressed) begin
            live_mode = 1'b1;
            blink_phase = 1'b0;
            frozen_level = item.gas_sample;
            return;
         end
         if (item.toggle_pressed) begin
            live_mode = !live_mode;
            if (live_mode) frozen_level = item.gas_sample;
         end
         if (live_mode) frozen_level = item.gas_sample;
         want.shown_level = frozen_level;
         want.active_flag = live_mode;
         if (frozen_level < thr.none_th) want.warn_level = WARN_NONE;
         else if (frozen_level < thr.low_th) want.warn_level = WARN_LOW;
         else if (frozen_level < thr.high_th) want.warn_level = WARN_HIGH;
         else want.warn_level = WARN_SEVERE;
         case (want.warn_level)
            WARN_NONE: begin
               want.blue_on = 1'b1;
            end
            WARN_LOW: begin
               want.red_on = 1'b1;
               want.green_on = 1'b1;
            end
            WARN_HIGH: begin
               advance_blink(item.now_ms, SLOW_HALF_MS);
               want.red_on = blink_phase;
            end
            default: begin
               advance_blink(item.now_ms, severe_half_ms(32'(frozen_level)));
               want.red_on = blink_phase;
               want.buzzer_on = !blink_phase;
               want.relay_on = 1'b1;
            end
         endcase
         pending_alarms.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            failures++;
            if (failures <= 10)
               $display("mismatch on %s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_alarm(rsp_type got);
         rsp_type want;
         if (pending_alarms.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result transfer: shown_level %0d", got.shown_level);
            return;
         end
         want = pending_alarms.pop_front();
         compare_field("shown_level", 32'(want.shown_level), 32'(got.shown_level));
         compare_field("active_flag", 32'(want.active_flag), 32'(got.active_flag));
         compare_field("warn_level", 32'(want.warn_level), 32'(got.warn_level));
         compare_field("red_on", 32'(want.red_on), 32'(got.red_on));
         compare_field("green_on", 32'(want.green_on), 32'(got.green_on));
         compare_field("blue_on", 32'(want.blue_on), 32'(got.blue_on));
         compare_field("buzzer_on", 32'(want.buzzer_on), 32'(got.buzzer_on));
         compare_field("relay_on", 32'(want.relay_on), 32'(got.relay_on));
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = REG_NONE_TH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   alarm_scoreboard sb = new();
   bit              calm = 0;
   int              stall_left = 0;
   logic [TIME_W-1:0] clock_ms;

   gas_level_alarm_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_200_000;
      $display("gas_level_alarm_controller regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_alarm(rsp_tdata);
   end

   // Called and returns just after a rising edge; tvalid stays high on return.
   task automatic send_pass(int unsigned sample, logic [TIME_W-1:0] now, bit tog, bit rst);
      req_type item;
      item = '0;
      item.gas_sample = LEVEL_W'(sample);
      item.now_ms = now;
      item.toggle_pressed = tog;
      item.reset_pressed = rst;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= item;
      do @(posedge clock); while (!req_tready);
      sb.predict_pass(item);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (sb.pending_alarms.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(alarm_settings_type s);
      reg_index_type idx;
      sb.thr = s;
      idx = REG_NONE_TH;
      do begin
         csr_we <= 1'b1;
         csr_addr <= idx;
         csr_wdata <= sb.reg_value(idx);
         @(posedge clock);
         idx = idx.next();
      end while (idx != REG_NONE_TH);
      csr_we <= 1'b0;
   endtask

   task automatic run_loop_passes(int count);
      int target;
      int sample;
      logic [TIME_W-1:0] stamp;
      target = 0;
      clock_ms = $urandom();
      for (int k = 0; k < count; k++) begin
         if (k % 20 == 0) begin
            case ($urandom_range(0, 4))
               0: target = int'(sb.thr.none_th);
               1: target = int'(sb.thr.low_th);
               2: target = int'(sb.thr.high_th);
               3: target = int'(FULL_SCALE - $urandom_range(0, 300));
               default: target = int'($urandom_range(0, FULL_SCALE));
            endcase
         end
         if ($urandom_range(0, 6) == 0) begin
            // noise: arbitrary time and buttons
            stamp = $urandom();
            if ($urandom_range(0, 1) == 1) clock_ms = stamp;
            send_pass($urandom_range(0, FULL_SCALE), stamp,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            clock_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 700)
                                                     : $urandom_range(20, 80);
            sample = target + int'($urandom_range(0, 80)) - 40;
            if (sample < 0) sample = 0;
            if (sample > int'(FULL_SCALE)) sample = int'(FULL_SCALE);
            send_pass(sample, clock_ms, $urandom_range(0, 11) == 0,
                      $urandom_range(0, 24) == 0);
         end
      end
      drain_and_settle();
   endtask

   function automatic alarm_settings_type random_settings();
      alarm_settings_type s;
      logic [LEVEL_W-1:0] a, b, c, t;
      a = LEVEL_W'($urandom_range(0, FULL_SCALE));
      b = LEVEL_W'($urandom_range(0, FULL_SCALE));
      c = LEVEL_W'($urandom_range(0, FULL_SCALE - 1));
      if ($urandom_range(0, 2) != 0) begin
         if (a > b) begin t = a; a = b; b = t; end
         if (b > c) begin t = b; b = c; c = t; end
         if (a > b) begin t = a; a = b; b = t; end
      end
      s.none_th = a;
      s.low_th = b;
      s.high_th = c;
      s.min_hz = HZ_W'($urandom_range(1, 63));
      s.max_hz = HZ_W'($urandom_range(1, 63));
      return s;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_pass(0, 0, 1'b0, 1'b0);
      send_pass(199, 10, 1'b0, 1'b0);
      send_pass(200, 20, 1'b0, 1'b0);
      send_pass(999, 30, 1'b0, 1'b0);
      send_pass(1000, 40, 1'b0, 1'b0);
      send_pass(2999, 520, 1'b0, 1'b0);
      send_pass(3000, 600, 1'b0, 1'b0);
      send_pass(4095, 700, 1'b0, 1'b0);
      send_pass(3500, 760, 1'b0, 1'b0);
      send_pass(3500, 900, 1'b0, 1'b0);
      send_pass(100, 950, 1'b1, 1'b0);
      send_pass(0, 1000, 1'b0, 1'b0);
      send_pass(150, 1100, 1'b1, 1'b0);
      send_pass(2500, 1200, 1'b0, 1'b1);
      send_pass(3200, 1300, 1'b1, 1'b1);
      send_pass(4000, 1400, 1'b1, 1'b0);
      send_pass(10, 1500, 1'b0, 1'b0);
      send_pass(10, 1600, 1'b0, 1'b1);
      send_pass(2000, 32'hFFFF_FF00, 1'b0, 1'b0);
      send_pass(2000, 32'h0000_0100, 1'b0, 1'b0);
      send_pass(2000, 32'h0000_0000, 1'b0, 1'b0);
      send_pass(4095, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_pass(0, 32'hFFFF_FFFF, 1'b1, 1'b0);
      drain_and_settle();

      load_settings('{12'd4095, 12'd4095, 12'd4094, 6'd1, 6'd63});
      run_loop_passes(60);
      load_settings('{12'd0, 12'd0, 12'd0, 6'd63, 6'd1});
      run_loop_passes(60);
      load_settings('{12'd0, 12'd0, 12'd4094, 6'd1, 6'd63});
      run_loop_passes(60);
      repeat (6) begin
         load_settings(random_settings());
         run_loop_passes(70);
      end
      calm = 1;
      load_settings('{12'd200, 12'd1000, 12'd3000, 6'd2, 6'd10});
      run_loop_passes(80);

      if (sb.failures == 0 && sb.pending_alarms.size() == 0) begin
         $display("gas_level_alarm_controller regression: pass");
      end else begin
         $display("gas_level_alarm_controller regression: fail");
      end
      $finish;
   end

endmodule
